[rtl/bptc_pkg.sv]
`default_nettype none
package bptc_pkg;

  // Field widths
  localparam int unsigned CAL_W   = 16;  // calibration word
  localparam int unsigned RAW_W   = 24;  // raw conversion result
  localparam int unsigned TOUT_W  = 19;  // compensated temperature
  localparam int unsigned PRS_W   = 32;  // compensated pressure
  localparam int unsigned CFG_IDX_W = 3;

  // Internal widths, sized to the value ranges
  localparam int unsigned DT_W   = 25;  // dT
  localparam int unsigned PT_W   = 42;  // dT * temperature coeff
  localparam int unsigned DD_W   = 50;  // dT squared
  localparam int unsigned CP_W   = 43;  // dT * offset/sensitivity coeff
  localparam int unsigned AB_W   = 20;  // TEMP-2000, TEMP+1500
  localparam int unsigned T2_W   = 17;  // T2
  localparam int unsigned SQ_W   = 40;  // squares of the above
  localparam int unsigned OS_W   = 44;  // OFF, SENS and their corrections
  localparam int unsigned SLO_W  = 22;  // low split of SENS for the product
  localparam int unsigned PLO_W  = RAW_W + SLO_W;      // 46
  localparam int unsigned PHI_W  = RAW_W + 1 + OS_W - SLO_W;  // 47
  localparam int unsigned PROD_W = 66;  // raw pressure * SENS
  localparam int unsigned Q_W    = 48;  // (product >> 21) - OFF

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TCO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TCO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFF  = 3'd5;

  // Temperature thresholds, relative to TEMP-2000
  localparam logic signed [AB_W-1:0] TEMP_REF_CENTI = 20'sd2000;
  localparam logic signed [AB_W-1:0] LOW_FROM_REF   = 20'sd3500;

  typedef struct packed {
    logic [CAL_W-1:0] press_sens;
    logic [CAL_W-1:0] press_off;
    logic [CAL_W-1:0] sens_tco;
    logic [CAL_W-1:0] off_tco;
    logic [CAL_W-1:0] temp_ref;
    logic [CAL_W-1:0] temp_coeff;
  } cal_t;

  // First-order results leaving stage 3
  typedef struct packed {
    logic                    valid;
    logic [RAW_W-1:0]        d1;
    logic signed [AB_W-1:0]  a;     // TEMP - 2000
    logic signed [AB_W-1:0]  b;     // TEMP + 1500
    logic [T2_W-1:0]         t2;    // already zero at or above 20.00
    logic signed [OS_W-1:0]  off1;
    logic signed [OS_W-1:0]  sens1;
  } s3_t;

  // Corrected terms leaving stage 6
  typedef struct packed {
    logic                    valid;
    logic [RAW_W-1:0]        d1;
    logic signed [OS_W-1:0]  off;
    logic signed [OS_W-1:0]  sens;
    logic signed [TOUT_W-1:0] tout;
  } s6_t;

endpackage
`default_nettype wire

[rtl/bptc_first_order.sv]
`default_nettype none
module bptc_first_order (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [bptc_pkg::RAW_W-1:0]  raw_pressure_i,
  input  wire logic [bptc_pkg::RAW_W-1:0]  raw_temperature_i,
  input  wire bptc_pkg::cal_t              cal_i,
  output bptc_pkg::s3_t                    s3_o
);
  import bptc_pkg::*;

  logic                   v1_q, v2_q, v3_q;
  logic [RAW_W-1:0]       d1_1_q, d1_2_q;
  logic signed [DT_W-1:0] dt_d, dt_q;
  logic signed [PT_W-1:0] pt_d, pt_q;
  logic [DD_W-1:0]        dd_d, dd_q;
  logic signed [CP_W-1:0] po_d, po_q, ps_d, ps_q;
  logic signed [AB_W-1:0] a_d;
  logic [DD_W+1:0]        dd3;
  s3_t                    s3_d, s3_q;

  // Stage 1: dT
  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_i.temp_ref, 8'h00});

  // Stage 2: the four products on dT
  assign pt_d = PT_W'(dt_q) * PT_W'($signed({1'b0, cal_i.temp_coeff}));
  assign dd_d = DD_W'(DD_W'(dt_q) * DD_W'(dt_q));
  assign po_d = CP_W'(dt_q) * CP_W'($signed({1'b0, cal_i.off_tco}));
  assign ps_d = CP_W'(dt_q) * CP_W'($signed({1'b0, cal_i.sens_tco}));

  // Stage 3: TEMP offsets, T2, first-order OFF and SENS
  assign a_d = AB_W'(pt_q >>> 23);
  assign dd3 = (DD_W+2)'(dd_q) + ((DD_W+2)'(dd_q) << 1);
  always_comb begin
    s3_d.valid = v2_q;
    s3_d.d1    = d1_2_q;
    s3_d.a     = a_d;
    s3_d.b     = a_d + LOW_FROM_REF;
    s3_d.t2    = a_d[AB_W-1] ? T2_W'(dd3 >> 33) : '0;
    s3_d.off1  = OS_W'($signed({1'b0, cal_i.press_off, 16'h0000})) + OS_W'(po_q >>> 7);
    s3_d.sens1 = OS_W'($signed({1'b0, cal_i.press_sens, 15'h0000})) + OS_W'(ps_q >>> 8);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_1_q <= raw_pressure_i;
      dt_q   <= dt_d;
      d1_2_q <= d1_1_q;
      pt_q   <= pt_d;
      dd_q   <= dd_d;
      po_q   <= po_d;
      ps_q   <= ps_d;
      s3_q   <= s3_d;
    end
  end

  always_comb begin
    s3_o       = s3_q;
    s3_o.valid = v3_q;
  end

  // A request taken lands in stage 1; a stall freezes the stages
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && valid_i) |=> v1_q) else $error("accepted request not in stage 1");
  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !valid_i) |=> !v1_q) else $error("bubble turned into an item");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable({v1_q, v2_q, v3_q})) else $error("stages moved during stall");

endmodule
`default_nettype wire

[rtl/bptc_second_order.sv]
`default_nettype none
module bptc_second_order (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire bptc_pkg::s3_t  s3_i,
  output bptc_pkg::s6_t       s6_o
);
  import bptc_pkg::*;

  logic                     v4_q, v5_q, v6_q;
  logic [RAW_W-1:0]         d1_4_q, d1_5_q;
  logic signed [SQ_W-1:0]   a2_q, b2_q;
  logic                     lo_q, vlo_q;
  logic signed [OS_W-1:0]   off1_4_q, sens1_4_q, off1_5_q, sens1_5_q;
  logic signed [TOUT_W-1:0] tout_d, tout_4_q, tout_5_q;
  logic signed [AB_W-1:0]   temp;
  logic signed [SQ_W+5:0]   m61, m29;
  logic signed [SQ_W+4:0]   b17, b9;
  logic signed [OS_W-1:0]   off2_d, sens2_d, off2_q, sens2_q;
  s6_t                      s6_d, s6_q;

  // Stage 4: squares, compensated temperature
  assign temp   = s3_i.a + TEMP_REF_CENTI;
  assign tout_d = TOUT_W'((AB_W+1)'(temp) - (AB_W+1)'($signed({1'b0, s3_i.t2})));

  // Stage 5: OFF2 = 61*a^2/16 (+17*b^2), SENS2 = 29*a^2/16 (+9*b^2)
  assign m61 = ((SQ_W+6)'(a2_q) <<< 6) - ((SQ_W+6)'(a2_q) <<< 2) + (SQ_W+6)'(a2_q);
  assign m29 = ((SQ_W+6)'(a2_q) <<< 5) - ((SQ_W+6)'(a2_q) <<< 1) - (SQ_W+6)'(a2_q);
  assign b17 = ((SQ_W+5)'(b2_q) <<< 4) + (SQ_W+5)'(b2_q);
  assign b9  = ((SQ_W+5)'(b2_q) <<< 3) + (SQ_W+5)'(b2_q);

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    if (lo_q) begin
      off2_d  = OS_W'(m61 >>> 4);
      sens2_d = OS_W'(m29 >>> 4);
      if (vlo_q) begin
        off2_d  = off2_d + OS_W'(b17);
        sens2_d = sens2_d + OS_W'(b9);
      end
    end
  end

  // Stage 6: corrected OFF and SENS
  always_comb begin
    s6_d.valid = v5_q;
    s6_d.d1    = d1_5_q;
    s6_d.off   = off1_5_q - off2_q;
    s6_d.sens  = sens1_5_q - sens2_q;
    s6_d.tout  = tout_5_q;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= s3_i.valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_4_q    <= s3_i.d1;
      a2_q      <= SQ_W'(s3_i.a) * SQ_W'(s3_i.a);
      b2_q      <= SQ_W'(s3_i.b) * SQ_W'(s3_i.b);
      lo_q      <= s3_i.a[AB_W-1];
      vlo_q     <= s3_i.b[AB_W-1];
      off1_4_q  <= s3_i.off1;
      sens1_4_q <= s3_i.sens1;
      tout_4_q  <= tout_d;
      d1_5_q    <= d1_4_q;
      off1_5_q  <= off1_4_q;
      sens1_5_q <= sens1_4_q;
      off2_q    <= off2_d;
      sens2_q   <= sens2_d;
      tout_5_q  <= tout_4_q;
      s6_q      <= s6_d;
    end
  end

  always_comb begin
    s6_o       = s6_q;
    s6_o.valid = v6_q;
  end

endmodule
`default_nettype wire

[rtl/bptc_pressure.sv]
`default_nettype none
module bptc_pressure (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire bptc_pkg::s6_t                s6_i,
  output logic                              valid_o,
  output logic signed [bptc_pkg::TOUT_W-1:0] tout_o,
  output logic signed [bptc_pkg::PRS_W-1:0]  press_o
);
  import bptc_pkg::*;

  logic                     v7_q, v8_q, v9_q;
  logic [PLO_W-1:0]         plo_q;
  logic signed [PHI_W-1:0]  phi_q;
  logic signed [OS_W-1:0]   off_7_q, off_8_q;
  logic signed [TOUT_W-1:0] tout_7_q, tout_8_q, tout_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [Q_W-1:0]    q;
  logic signed [PRS_W-1:0]  press_q;

  // Stage 8: join the two partial products of raw pressure * SENS
  assign prod_d = (PROD_W'(phi_q) <<< SLO_W) + PROD_W'($signed({1'b0, plo_q}));

  // Stage 9: ((product >> 21) - OFF) >> 15, kept to 32 bits
  assign q = Q_W'(prod_q >>> 21) - Q_W'(off_8_q);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en_i) begin
      v7_q <= s6_i.valid;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  // Payload; stage 7 splits SENS into an unsigned low and a signed high part
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q    <= PLO_W'(s6_i.d1) * PLO_W'(s6_i.sens[SLO_W-1:0]);
      phi_q    <= PHI_W'($signed({1'b0, s6_i.d1})) * PHI_W'($signed(s6_i.sens[OS_W-1:SLO_W]));
      off_7_q  <= s6_i.off;
      tout_7_q <= s6_i.tout;
      prod_q   <= prod_d;
      off_8_q  <= off_7_q;
      tout_8_q <= tout_7_q;
      press_q  <= PRS_W'(q >>> 15);
      tout_q   <= tout_8_q;
    end
  end

  assign valid_o = v9_q;
  assign tout_o  = tout_q;
  assign press_o = press_q;

endmodule
`default_nettype wire

[rtl/baro_pressure_temp_compensation.sv]
`default_nettype none
// Second-order compensation for a barometric sensor: each request on the slave
// stream carries one raw pressure and one raw temperature conversion, and each
// result on the master stream carries the compensated temperature and pressure
// in hundredths, using the six calibration words written through the register
// port (indexes 0..5, other indexes ignored; write only while no request is in
// flight). The datapath is a nine-stage pipeline: one request is taken every
// cycle while the master side is not stalled. A stall on the master side
// freezes every stage at once, so tready on the slave side follows the master
// side; nothing is dropped or repeated.
module baro_pressure_temp_compensation (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Calibration registers
  input  wire logic                              cfg_we_i,
  input  wire logic [bptc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bptc_pkg::CAL_W-1:0]        cfg_wdata_i,
  // Raw conversions
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [47:0]                       s_axis_tdata,  // raw_pressure, raw_temperature
  // Compensated results
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [55:0]                            m_axis_tdata   // temperature_centi, pressure_centi, pad
);
  import bptc_pkg::*;

  cal_t                     cal_q;
  logic                     pipe_en;
  s3_t                      s3;
  s6_t                      s6;
  logic signed [TOUT_W-1:0] tout;
  logic signed [PRS_W-1:0]  press;

  // Calibration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PRESS_SENS: cal_q.press_sens <= cfg_wdata_i;
        REG_PRESS_OFF:  cal_q.press_off  <= cfg_wdata_i;
        REG_SENS_TCO:   cal_q.sens_tco   <= cfg_wdata_i;
        REG_OFF_TCO:    cal_q.off_tco    <= cfg_wdata_i;
        REG_TEMP_REF:   cal_q.temp_ref   <= cfg_wdata_i;
        REG_TEMP_COEFF: cal_q.temp_coeff <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a result is held at the output
  assign pipe_en       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  bptc_first_order u_first (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (pipe_en),
    .valid_i           (s_axis_tvalid),
    .raw_pressure_i    (s_axis_tdata[23:0]),
    .raw_temperature_i (s_axis_tdata[47:24]),
    .cal_i             (cal_q),
    .s3_o              (s3)
  );

  bptc_second_order u_second (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .s3_i   (s3),
    .s6_o   (s6)
  );

  bptc_pressure u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .s6_i    (s6),
    .valid_o (m_axis_tvalid),
    .tout_o  (tout),
    .press_o (press)
  );

  assign m_axis_tdata = {5'b0, press, tout};

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import bptc_pkg::*;

  // Unused register slots; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint TEMP_REF_C = 2000;    // 20.00 degrees
  localparam longint TEMP_LOW_C = -1500;   // -15.00 degrees
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     DRAIN_CYCLES   = 20;  // pipeline is nine deep
  localparam int     ITEMS_PER_PHASE = 105;

  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
  localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

  // One conversion pair, raw pressure in the low bits as on tdata
  typedef struct packed {
    logic [RAW_W-1:0] raw_t;
    logic [RAW_W-1:0] raw_p;
  } conv_t;

  typedef struct {
    logic signed [TOUT_W-1:0] temp;
    logic signed [PRS_W-1:0]  press;
  } reading_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CAL_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata = '0;   // raw_pressure, raw_temperature
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [55:0]          m_axis_tdata;        // temperature_centi, pressure_centi, pad

  baro_pressure_temp_compensation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  conv_t    conv_q[$];      // requests not yet offered
  reading_t reading_q[$];   // expected readings, oldest first
  cal_t     cal_now = '0;   // calibration as the block should hold it
  int       in_flight = 0;  // requests offered but not yet answered
  int       errors = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  int       idle_cycles = 0;
  bit       no_idle = 1'b0;
  bit       in_taken = 1'b0;
  bit       out_taken = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Compensated temperature and pressure for one conversion pair
  function automatic reading_t compensate(conv_t c, cal_t k);
    reading_t r;
    longint d1, dt, temp, t2, off2, sens2, a, b, off, sens, p;
    d1    = longint'(c.raw_p);
    dt    = longint'(c.raw_t) - (longint'(k.temp_ref) <<< 8);
    temp  = TEMP_REF_C + ((dt * longint'(k.temp_coeff)) >>> 23);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    // second-order correction below 20.00, extra term below -15.00
    if (temp < TEMP_REF_C) begin
      a     = temp - TEMP_REF_C;
      t2    = (3 * (dt * dt)) >>> 33;
      off2  = (61 * (a * a)) >>> 4;
      sens2 = (29 * (a * a)) >>> 4;
      if (temp < TEMP_LOW_C) begin
        b     = temp - TEMP_LOW_C;
        off2  = off2 + 17 * (b * b);
        sens2 = sens2 + 9 * (b * b);
      end
    end
    off  = (longint'(k.press_off) <<< 16) + ((longint'(k.off_tco) * dt) >>> 7) - off2;
    sens = (longint'(k.press_sens) <<< 15) + ((longint'(k.sens_tco) * dt) >>> 8) - sens2;
    p    = (((d1 * sens) >>> 21) - off) >>> 15;
    r.temp  = TOUT_W'(temp - t2);
    r.press = PRS_W'(p);
    return r;
  endfunction

  function automatic conv_t make_conv(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
    conv_t c;
    c.raw_p = raw_p;
    c.raw_t = raw_t;
    return c;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  // Calibration word biased toward the extremes
  function automatic logic [CAL_W-1:0] rand_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CAL_MAX;
      default: return CAL_W'($urandom);
    endcase
  endfunction

  // Raw temperature: full range, or a spread of distances around the reference
  function automatic logic [RAW_W-1:0] rand_raw_t();
    int span, offs;
    if ($urandom_range(0, 1) == 0) return RAW_W'($urandom);
    span = $urandom_range(0, 22);
    offs = int'($urandom_range(0, 2 << span)) - (1 << span);
    return {cal_now.temp_ref, 8'h00} + RAW_W'(offs);
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw_p();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RAW_MAX;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_PRESS_SENS: cal_now.press_sens = val;
      REG_PRESS_OFF:  cal_now.press_off  = val;
      REG_SENS_TCO:   cal_now.sens_tco   = val;
      REG_OFF_TCO:    cal_now.off_tco    = val;
      REG_TEMP_REF:   cal_now.temp_ref   = val;
      REG_TEMP_COEFF: cal_now.temp_coeff = val;
      default: ;
    endcase
  endtask

  // Load all six words, poke the spare slots, then release the write enable
  task automatic program_cal(cal_t k);
    write_reg(REG_PRESS_SENS, k.press_sens);
    write_reg(REG_SPARE_LO, rand_word());
    write_reg(REG_PRESS_OFF, k.press_off);
    write_reg(REG_SENS_TCO, k.sens_tco);
    write_reg(REG_OFF_TCO, k.off_tco);
    write_reg(REG_TEMP_REF, k.temp_ref);
    write_reg(REG_SPARE_HI, rand_word());
    write_reg(REG_TEMP_COEFF, k.temp_coeff);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic await_drain();
    while (conv_q.size() != 0 || in_flight != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Request driver
  always @(negedge clk_i) begin
    if (rst_ni && (in_taken || !s_axis_tvalid)) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (conv_q.size() != 0) begin
        s_axis_tdata  <= conv_q.pop_front();
        s_axis_tvalid <= 1'b1;
        in_flight++;
        gap_left = draw_wait();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) hold_left = draw_wait();
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: check results, then predict for newly accepted requests
  always @(posedge clk_i) begin
    reading_t got, want;
    in_taken  = s_axis_tvalid && s_axis_tready;
    out_taken = m_axis_tvalid && m_axis_tready;
    if (out_taken) begin
      got.temp  = m_axis_tdata[TOUT_W-1:0];
      got.press = m_axis_tdata[TOUT_W +: PRS_W];
      if (reading_q.size() == 0) begin
        report_mismatch("result with no request pending", got.press, 0);
      end else begin
        want = reading_q.pop_front();
        in_flight--;
        if (got.temp !== want.temp)
          report_mismatch("temperature_centi", got.temp, want.temp);
        if (got.press !== want.press)
          report_mismatch("pressure_centi", got.press, want.press);
      end
    end
    if (in_taken) reading_q.push_back(compensate(conv_t'(s_axis_tdata), cal_now));
  end

  // Watchdog on cycles with no transfer on either side
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    cal_t        k;
    logic [23:0] ref_t;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset calibration (all zero)
    conv_q.push_back(make_conv('0, '0));
    conv_q.push_back(make_conv(RAW_MAX, RAW_MAX));
    await_drain();

    // Typical sensor calibration; walk the temperature thresholds
    k = '{press_sens: 16'd40127, press_off: 16'd36924, sens_tco: 16'd23317,
          off_tco: 16'd23282, temp_ref: 16'd33464, temp_coeff: 16'd28312};
    program_cal(k);
    ref_t = {k.temp_ref, 8'h00};
    conv_q.push_back(make_conv(24'd9085466, ref_t));            // exactly 20.00
    conv_q.push_back(make_conv(24'd9085466, ref_t - 24'd1));    // just below 20.00
    conv_q.push_back(make_conv(24'd9085466, ref_t + 24'd1));
    conv_q.push_back(make_conv(RAW_MAX, ref_t - 24'd1037020));  // -15.00, no extra term
    conv_q.push_back(make_conv(RAW_MAX, ref_t - 24'd1037021));  // -15.01, extra term
    conv_q.push_back(make_conv('0, '0));
    conv_q.push_back(make_conv(RAW_MAX, RAW_MAX));
    conv_q.push_back(make_conv(RAW_MAX, '0));
    conv_q.push_back(make_conv('0, RAW_MAX));
    conv_q.push_back(make_conv(24'h555555, 24'hAAAAAA));
    conv_q.push_back(make_conv(24'hAAAAAA, 24'h555555));
    await_drain();

    // All calibration words at maximum
    k = '{CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX};
    program_cal(k);
    conv_q.push_back(make_conv('0, '0));
    conv_q.push_back(make_conv(RAW_MAX, RAW_MAX));
    conv_q.push_back(make_conv(RAW_MAX, '0));
    conv_q.push_back(make_conv('0, RAW_MAX));
    conv_q.push_back(make_conv(RAW_MAX, {CAL_MAX, 8'h00}));
    await_drain();

    // Random phases: typical calibration first, then random words
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        k.press_sens = rand_word();
        k.press_off  = rand_word();
        k.sens_tco   = rand_word();
        k.off_tco    = rand_word();
        k.temp_ref   = rand_word();
        k.temp_coeff = rand_word();
      end else begin
        k = '{press_sens: 16'd40127, press_off: 16'd36924, sens_tco: 16'd23317,
              off_tco: 16'd23282, temp_ref: 16'd33464, temp_coeff: 16'd28312};
      end
      program_cal(k);
      no_idle = (ph == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        conv_q.push_back(make_conv(rand_raw_p(), rand_raw_t()));
      await_drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
